// File: sv/pbr_neutral_tonemapper_top_defines.svh
// Assertion macros shared by the tone mapper checker.
`ifndef PBR_NEUTRAL_TONEMAPPER_TOP_DEFINES_SVH
`define PBR_NEUTRAL_TONEMAPPER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset
`define PBRNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define PBRNT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pbrnt_pkg.sv
// Shared types and fixed constants of the PBR neutral tone mapper.
`timescale 1ns / 1ps
`default_nettype none
package pbrnt_pkg;

  // Operator constants in hundredths
  localparam int PCT_START    = 76;
  localparam int PCT_DESAT    = 15;
  localparam int PCT_TOE      = 8;
  localparam int PCT_TOE_OFF  = 4;
  localparam int PCT_SCALE    = 100;
  // 6.25 = 25/4
  localparam int TOE_MUL      = 25;

  // Pipeline control handed into a stage chain
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// File: sv/pbrnt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module pbrnt_div
  import pbrnt_pkg::*;
#(
  parameter int DEN_W  = 25,
  parameter int Q_W    = 18,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pipe_ctl_t              ctl,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quot,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int W = DEN_W + Q_W;

  logic [W-1:0]      rem   [0:Q_W];
  logic [DEN_W-1:0]  dens  [0:Q_W];
  logic [Q_W-1:0]    qs    [0:Q_W];
  logic [SIDE_W-1:0] sides [0:Q_W];
  logic              vs    [0:Q_W];

  assign rem[0]   = num;
  assign dens[0]  = den;
  assign qs[0]    = '0;
  assign sides[0] = side;
  assign vs[0]    = ctl.valid;

  // One stage per quotient bit, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [W-1:0] shifted;
    logic         fits;
    assign shifted = {{Q_W{1'b0}}, dens[k]} << B;
    assign fits    = rem[k] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k+1]   <= fits ? rem[k] - shifted : rem[k];
        qs[k+1]    <= qs[k] | ({{(Q_W-1){1'b0}}, fits} << B);
        dens[k+1]  <= dens[k];
        sides[k+1] <= sides[k];
      end
    end
  end

  assign out_valid = vs[Q_W];
  assign quot      = qs[Q_W];
  assign side_out  = sides[Q_W];

endmodule
`default_nettype wire

// File: sv/pbr_neutral_tonemapper_top.sv
// Top level of the PBR neutral tone mapper pipeline.
//
//  Port group   Dir  Contents
//  s_axis       in   tdata: in_red, in_green, in_blue (INT_BITS+FRAC_BITS each)
//  m_axis       out  tdata: out_red, out_green, out_blue (FRAC_BITS+1 each)
//
// One pixel per clock while the output is not stalled; the two pipelined
// divider chains resolve one quotient bit per stage.
// rst is synchronous and clears only the valid bits of the stages.
// When the output holds a pixel that is not taken, the whole pipe halts
// and s_tready falls in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module pbr_neutral_tonemapper_top
  import pbrnt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // in_red, in_green, in_blue from bit 0 up, zero padded to bytes
  input  logic [((3*(INT_BITS+FRAC_BITS)+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_red, out_green, out_blue from bit 0 up, zero padded to bytes
  output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

  localparam int F     = FRAC_BITS;
  localparam int IN_W  = INT_BITS + FRAC_BITS;
  localparam int O_W   = F + 1;
  localparam int QD_W  = F + 2;
  localparam int OUT_DW = ((3*O_W+7)/8)*8;

  localparam logic [IN_W:0] ONE   = (IN_W+1)'(1) << F;
  localparam logic [IN_W:0] HALF  = (IN_W+1)'(1) << (F-1);
  localparam logic [IN_W:0] K_START =
    (IN_W+1)'((PCT_START * (2**F) + PCT_SCALE/2) / PCT_SCALE);
  localparam logic [IN_W:0] K_D   = ONE - K_START;
  localparam logic [F-1:0]  K_DESAT =
    F'((PCT_DESAT * (2**F) + PCT_SCALE/2) / PCT_SCALE);
  localparam logic [F-1:0]  K_TOE =
    F'((PCT_TOE * (2**F) + PCT_SCALE/2) / PCT_SCALE);
  localparam logic [F-1:0]  K_TOE_OFF =
    F'((PCT_TOE_OFF * (2**F) + PCT_SCALE/2) / PCT_SCALE);
  localparam logic [F-1:0]  K_D_F = K_D[F-1:0];
  localparam logic [2*F-1:0] K_D_SQ = {{F{1'b0}}, K_D_F} * {{F{1'b0}}, K_D_F};

  localparam int N1_W = IN_W + 1 + QD_W;   // divider numerator widths
  localparam int NS_W = IN_W + QD_W;

  logic      adv;
  pipe_ctl_t ctl_in;
  pipe_ctl_t ctl_s5;

  // Whole pipe moves when the output register is free or being emptied
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 0: capture the request
  logic            v0;
  logic [IN_W-1:0] c0 [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c0[0] <= s_tdata[IN_W-1:0];
      c0[1] <= s_tdata[2*IN_W-1:IN_W];
      c0[2] <= s_tdata[3*IN_W-1:2*IN_W];
    end
  end

  // Stage 1: minimum channel and square of it
  logic [IN_W-1:0] x_c;
  logic            v1, small1;
  logic [IN_W-1:0] x1;
  logic [2*F-1:0]  xx1;
  logic [IN_W-1:0] c1 [0:2];
  always_comb begin
    x_c = c0[0];
    if (c0[1] < x_c) x_c = c0[1];
    if (c0[2] < x_c) x_c = c0[2];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= x_c;
      small1 <= x_c < {{(IN_W-F){1'b0}}, K_TOE};
      xx1    <= {{F{1'b0}}, x_c[F-1:0]} * {{F{1'b0}}, x_c[F-1:0]};
      c1     <= c0;
    end
  end

  // Stage 2: toe offset and subtraction
  logic [2*F+4:0]  sq_full;
  logic [2*F+4:0]  sq;
  logic [IN_W-1:0] off;
  logic            v2;
  logic [IN_W-1:0] c2 [0:2];
  always_comb begin
    sq_full = (2*F+5)'(TOE_MUL) * {5'b0, xx1} + ((2*F+5)'(1) << (F+1));
    sq      = sq_full >> (F+2);
    if (small1) begin
      off = (sq > {{(2*F+5-IN_W){1'b0}}, x1}) ? '0 : x1 - sq[IN_W-1:0];
    end else begin
      off = {{(IN_W-F){1'b0}}, K_TOE_OFF};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c2[i] <= (c1[i] > off) ? c1[i] - off : '0;
      end
    end
  end

  // Stage 3: peak, path select and divider operands for the new peak
  logic [IN_W-1:0] peak_c;
  logic [IN_W:0]   den1_c;
  logic            v3, byp3;
  logic [IN_W-1:0] peak3;
  logic [IN_W:0]   den1;
  logic [N1_W-1:0] num1;
  logic [IN_W-1:0] c3 [0:2];
  always_comb begin
    peak_c = c2[0];
    if (c2[1] > peak_c) peak_c = c2[1];
    if (c2[2] > peak_c) peak_c = c2[2];
    den1_c = {1'b0, peak_c} - K_START + K_D;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      peak3 <= peak_c;
      byp3  <= {1'b0, peak_c} < K_START;
      den1  <= den1_c;
      num1  <= N1_W'(K_D_SQ) + N1_W'(den1_c >> 1);
      c3    <= c2;
    end
  end

  // Divider one: d*d over the compression denominator
  localparam int SIDE1_W = 1 + 4*IN_W;
  logic               vd1;
  logic [QD_W-1:0]    q1;
  logic [SIDE1_W-1:0] side1;
  assign ctl_in = '{en: adv, valid: v3};
  pbrnt_div #(.DEN_W(IN_W+1), .Q_W(QD_W), .SIDE_W(SIDE1_W)) u_div_peak (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_in),
    .num      (num1),
    .den      (den1),
    .side     ({byp3, c3[2], c3[1], c3[0], peak3}),
    .out_valid(vd1),
    .quot     (q1),
    .side_out (side1)
  );

  // Stage 4: new peak and the products that feed the second dividers
  logic [O_W-1:0]  newp_c;
  logic [IN_W-1:0] peak_d;
  logic [IN_W-1:0] diff_c;
  logic            v4, byp4;
  logic [IN_W-1:0] peak4;
  logic [O_W-1:0]  newp4;
  logic [IN_W+F-1:0] tprod4;
  logic [IN_W+O_W-1:0] sprod4 [0:2];
  logic [IN_W-1:0] c4 [0:2];
  assign peak_d = side1[IN_W-1:0];
  always_comb begin
    newp_c = ({1'b0, q1} > (QD_W+1)'(ONE)) ? '0 : O_W'(ONE) - q1[O_W-1:0];
    diff_c = (peak_d > IN_W'(newp_c)) ? peak_d - IN_W'(newp_c) : '0;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= vd1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      peak4  <= peak_d;
      newp4  <= newp_c;
      byp4   <= side1[SIDE1_W-1];
      tprod4 <= {{IN_W{1'b0}}, K_DESAT} * {{F{1'b0}}, diff_c};
      for (int i = 0; i < 3; i++) begin
        c4[i]     <= side1[(i+1)*IN_W +: IN_W];
        sprod4[i] <= {{O_W{1'b0}}, side1[(i+1)*IN_W +: IN_W]} *
                     {{IN_W{1'b0}}, newp_c};
      end
    end
  end

  // Stage 5: rounding addends and operands of the weight and scale dividers
  logic [IN_W+F-1:0] t_full;
  logic [IN_W-1:0]   t_c;
  logic [IN_W:0]     gden_c;
  logic              v5, byp5;
  logic [O_W-1:0]    newp5;
  logic [IN_W:0]     gden;
  logic [N1_W-1:0]   gnum;
  logic [IN_W-1:0]   peak5;
  logic [NS_W-1:0]   snum [0:2];
  logic [IN_W-1:0]   c5 [0:2];
  always_comb begin
    t_full = tprod4 + (IN_W+F)'(HALF);
    t_c    = t_full[IN_W+F-1:F];
    gden_c = {1'b0, t_c} + ONE;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      byp5  <= byp4;
      newp5 <= newp4;
      peak5 <= peak4;
      gden  <= gden_c;
      gnum  <= (N1_W'(t_c) << F) + N1_W'(gden_c >> 1);
      c5    <= c4;
      for (int i = 0; i < 3; i++) begin
        snum[i] <= NS_W'(sprod4[i]) + NS_W'(peak4 >> 1);
      end
    end
  end

  // Divider two: desaturation weight, and the three channel scalings
  assign ctl_s5 = '{en: adv, valid: v5};
  logic            vg;
  logic [QD_W-1:0] gq;
  logic [O_W:0]    gside;
  pbrnt_div #(.DEN_W(IN_W+1), .Q_W(QD_W), .SIDE_W(O_W+1)) u_div_weight (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_s5),
    .num      (gnum),
    .den      (gden),
    .side     ({byp5, newp5}),
    .out_valid(vg),
    .quot     (gq),
    .side_out (gside)
  );

  logic [QD_W-1:0] sq_q  [0:2];
  logic [IN_W-1:0] cside [0:2];
  logic            sv    [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_scale
    pbrnt_div #(.DEN_W(IN_W), .Q_W(QD_W), .SIDE_W(IN_W)) u_div_scale (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl_s5),
      .num      (snum[i]),
      .den      (peak5),
      .side     (c5[i]),
      .out_valid(sv[i]),
      .quot     (sq_q[i]),
      .side_out (cside[i])
    );
  end

  // Stage 6: clamp the scaled channel and form the mix product
  logic [O_W-1:0]  newp_g;
  logic [O_W-1:0]  s_c [0:2];
  logic            v6, byp6;
  logic [O_W-1:0]  s6 [0:2];
  logic [2*O_W-1:0] dm6 [0:2];
  logic [IN_W-1:0] c6 [0:2];
  assign newp_g = gside[O_W-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_c[i] = (sq_q[i] > QD_W'(newp_g)) ? newp_g : sq_q[i][O_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= vg && sv[0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      byp6 <= gside[O_W];
      for (int i = 0; i < 3; i++) begin
        s6[i]  <= s_c[i];
        c6[i]  <= cside[i];
        dm6[i] <= {{O_W{1'b0}}, newp_g - s_c[i]} * {{O_W{1'b0}}, gq[O_W-1:0]};
      end
    end
  end

  // Stage 7: final mix, saturation and the output register
  logic [2*O_W-1:0] mix [0:2];
  logic [O_W:0]     r   [0:2];
  logic [O_W-1:0]   res [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix[i] = dm6[i] + (2*O_W)'(HALF);
      r[i]   = {1'b0, s6[i]} + (O_W+1)'(mix[i] >> F);
      if (byp6) begin
        res[i] = ({1'b0, c6[i]} > ONE) ? O_W'(ONE) : c6[i][O_W-1:0];
      end else begin
        res[i] = (r[i] > (O_W+1)'(ONE)) ? O_W'(ONE) : r[i][O_W-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_DW'({res[2], res[1], res[0]});
    end
  end

endmodule
`default_nettype wire

// File: sv/pbrnt_check.sv
// Port-level checker for the tone mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pbr_neutral_tonemapper_top_defines.svh"
module pbrnt_check #(
  parameter int FRAC_BITS = 16,
  parameter int OUT_DW    = 56
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [OUT_DW-1:0] m_tdata
);

  localparam int O_W = FRAC_BITS + 1;
  localparam logic [O_W-1:0] ONE = O_W'(1) << FRAC_BITS;

  // Output register is empty after reset
  `PBRNT_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result after reset")
  // A refused result is held unchanged
  `PBRNT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  // Input side moves exactly when the output slot can move
  `PBRNT_ASSERT(a_ready, 1'b1 |-> (s_tready == (!m_tvalid || m_tready)), "ready mismatch")
  // Every channel saturates at one
  `PBRNT_ASSERT(a_range, m_tvalid |-> m_tdata[O_W-1:0] <= ONE && m_tdata[2*O_W-1:O_W] <= ONE && m_tdata[3*O_W-1:2*O_W] <= ONE, "channel above one")

endmodule

bind pbr_neutral_tonemapper_top pbrnt_check #(
  .FRAC_BITS(FRAC_BITS),
  .OUT_DW   (((3*(FRAC_BITS+1)+7)/8)*8)
) u_pbrnt_check (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

// File: dv/pbrnt_checker.sv
// Checker for the tone mapper: watches both streams, predicts and compares.
`timescale 1ns / 1ps
module pbrnt_checker
  import pbrnt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 8,
  parameter int IW = ((3*(INT_BITS+FRAC_BITS)+7)/8)*8,
  parameter int OW = ((3*(FRAC_BITS+1)+7)/8)*8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [IW-1:0] s_tdata,
  input  logic          m_tvalid,
  input  logic          m_tready,
  input  logic [OW-1:0] m_tdata,
  output int            fail_count,
  output int            pending
);

  localparam int CW = INT_BITS + FRAC_BITS;
  localparam int PW = FRAC_BITS + 1;
  localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned K_START =
    ((64'(PCT_START) << FRAC_BITS) + PCT_SCALE/2) / PCT_SCALE;
  localparam longint unsigned K_D = ONE - K_START;
  localparam longint unsigned K_DESAT =
    ((64'(PCT_DESAT) << FRAC_BITS) + PCT_SCALE/2) / PCT_SCALE;
  localparam longint unsigned K_TOE =
    ((64'(PCT_TOE) << FRAC_BITS) + PCT_SCALE/2) / PCT_SCALE;
  localparam longint unsigned K_TOE_OFF =
    ((64'(PCT_TOE_OFF) << FRAC_BITS) + PCT_SCALE/2) / PCT_SCALE;

  typedef struct packed {
    logic [PW-1:0] blue;
    logic [PW-1:0] green;
    logic [PW-1:0] red;
  } rgb_out_t;

  rgb_out_t tone_expected[$];

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic logic [PW-1:0] clip_one(longint unsigned v);
    return PW'(v > ONE ? ONE : v);
  endfunction

  // Neutral tone curve on one pixel
  function automatic rgb_out_t tone_map(logic [IW-1:0] px);
    longint unsigned c[3];
    longint unsigned lo, off, sq, peak, q, newp, diff, t, g, s, r;
    rgb_out_t o;
    logic [PW-1:0] res[3];
    for (int i = 0; i < 3; i++) c[i] = px[i*CW +: CW];
    lo = c[0];
    if (c[1] < lo) lo = c[1];
    if (c[2] < lo) lo = c[2];
    // toe offset from the darkest channel
    if (lo < K_TOE) begin
      sq = (25 * lo * lo + (64'd1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
      off = sq > lo ? 0 : lo - sq;
    end else begin
      off = K_TOE_OFF;
    end
    for (int i = 0; i < 3; i++) c[i] = c[i] > off ? c[i] - off : 0;
    peak = c[0];
    if (c[1] > peak) peak = c[1];
    if (c[2] > peak) peak = c[2];
    if (peak < K_START) begin
      for (int i = 0; i < 3; i++) res[i] = clip_one(c[i]);
    end else begin
      // highlight compression and desaturation
      q = rdiv(K_D * K_D, peak - K_START + K_D);
      newp = q > ONE ? 0 : ONE - q;
      diff = peak > newp ? peak - newp : 0;
      t = (K_DESAT * diff + HALF) >> FRAC_BITS;
      g = rdiv(t << FRAC_BITS, t + ONE);
      for (int i = 0; i < 3; i++) begin
        s = rdiv(c[i] * newp, peak);
        if (s > newp) s = newp;
        r = s + (((newp - s) * g + HALF) >> FRAC_BITS);
        res[i] = clip_one(r);
      end
    end
    o.red = res[0];
    o.green = res[1];
    o.blue = res[2];
    return o;
  endfunction

  assign pending = tone_expected.size();

  // Predict on every accepted request, compare every accepted result
  always @(posedge clk) begin
    rgb_out_t want, got;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) tone_expected.push_back(tone_map(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[3*PW-1:0];
        if (tone_expected.size() == 0) begin
          $error("unexpected pixel %h", got);
          errs++;
        end else begin
          want = tone_expected.pop_front();
          if (got.red !== want.red) begin
            $error("out_red: expected %0d actual %0d", want.red, got.red);
            errs++;
          end
          if (got.green !== want.green) begin
            $error("out_green: expected %0d actual %0d", want.green, got.green);
            errs++;
          end
          if (got.blue !== want.blue) begin
            $error("out_blue: expected %0d actual %0d", want.blue, got.blue);
            errs++;
          end
        end
      end
      // one update per clock, however many fields differ
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: dv/testbench.sv
// Testbench top: stimulus, stall patterns and verdict for the tone mapper.
`timescale 1ns / 1ps
module testbench;
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int CW = INT_BITS + FRAC_BITS;
  localparam int IW = ((3*CW+7)/8)*8;
  localparam int OW = ((3*(FRAC_BITS+1)+7)/8)*8;
  localparam int LATENCY = 2*FRAC_BITS + 12;
  localparam int N_RANDOM = 800;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IW-1:0] s_tdata;
  logic [OW-1:0] m_tdata;
  int fail_count, pending;
  int idle_cycles;
  int unsigned stall_phase;
  logic [CW-1:0] pixel_q[$];

  pbr_neutral_tonemapper_top #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  pbrnt_checker #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls: periodic windows plus random drops, with clean stretches
  initial m_tready = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[11:9] == 3'd5) m_tready <= 1'b1;
    else if (stall_phase[5:3] == 3'd6) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** pbr_neutral_tonemapper_top: FAILED **");
      $finish;
    end
  end

  // Random channel biased towards toe, knee and overload regions
  function automatic logic [CW-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 6000));
      1: return CW'($urandom_range(40000, 60000));
      2: return CW'($urandom_range(0, 2 * 65536));
      3: return CW'($urandom_range(0, 16 * 65536));
      4: return {CW{1'b1}} - CW'($urandom_range(0, 255));
      default: return CW'($urandom());
    endcase
  endfunction

  task automatic add_px(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
    pixel_q.push_back(r);
    pixel_q.push_back(g);
    pixel_q.push_back(b);
  endtask

  // Push one pixel, holding valid across bursts
  task automatic send_px(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
    s_tvalid <= 1'b1;
    s_tdata <= IW'({b, g, r});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int burst;
    logic [CW-1:0] pr, pg, pb;
    s_tvalid = 0;
    s_tdata = '0;
    stall_phase = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed pixels: black, all ones, toe edges, knee threshold, single channels
    add_px(0, 0, 0);
    add_px({CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}});
    add_px({CW{1'b1}}, 0, 0);
    add_px(0, {CW{1'b1}}, 0);
    add_px(0, 0, {CW{1'b1}});
    add_px(5242, 5242, 5242);
    add_px(5243, 5243, 5243);
    add_px(5243, 60000, 5243);
    add_px(CW'(49807 + 2621), CW'(49807 + 2621), CW'(49807 + 2621));
    add_px(CW'(49806 + 2621), 3000, 20000);
    add_px(ONE_FX, ONE_FX, ONE_FX);
    add_px(ONE_FX, 0, ONE_FX >> 1);
    add_px(ONE_FX << 3, ONE_FX << 1, 100);
    add_px(1, 1, 1);
    add_px(1, 2, 3);
    add_px(10000, 70000, 200000);
    add_px(24'haaaaaa, 24'h555555, 24'h0f0f0f);
    add_px(24'h555555, 24'haaaaaa, 24'hf0f0f0);
    for (int i = 0; i < N_RANDOM; i++) add_px(rand_chan(), rand_chan(), rand_chan());
    for (int n = 0; pixel_q.size() > 0; n++) begin
      // one drain pause midway
      if (n == 400) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      pr = pixel_q.pop_front();
      pg = pixel_q.pop_front();
      pb = pixel_q.pop_front();
      send_px(pr, pg, pb);
      if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 30);
        if ($urandom_range(0, 2) != 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d directed and %0d random pixels: toe, knee, compression and",
             18, N_RANDOM);
    $display("saturated inputs, with bursty requests and receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("** pbr_neutral_tonemapper_top: PASSED **");
    end else begin
      $display("** pbr_neutral_tonemapper_top: FAILED **");
    end
    $finish;
  end
endmodule
